// File: design/clle_pkg.sv
package clle_pkg;

    localparam int NODES     = 64;
    localparam int DATA_BITS = 32;
    localparam int IDX_W     = $clog2(NODES);
    localparam int PTR_W     = IDX_W + 1;
    localparam int LEN_W     = 7;
    localparam int ST_W      = 2;
    localparam int REQ_W     = 4;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND     = 4'd0,
        REQ_PREPEND    = 4'd1,
        REQ_INS_BEFORE = 4'd2,
        REQ_INS_AFTER  = 4'd3,
        REQ_DEL_FRONT  = 4'd4,
        REQ_DEL_BACK   = 4'd5,
        REQ_DEL_CURSOR = 4'd6,
        REQ_MV_FRONT   = 4'd7,
        REQ_MV_BACK    = 4'd8,
        REQ_MV_PREV    = 4'd9,
        REQ_MV_NEXT    = 4'd10,
        REQ_RD_FRONT   = 4'd11,
        REQ_RD_BACK    = 4'd12,
        REQ_RD_CURSOR  = 4'd13,
        REQ_WR_CURSOR  = 4'd14,
        REQ_CLEAR      = 4'd15
    } req_t;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDEF = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

endpackage

// File: design/clle_ram.sv
module clle_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic                 re,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: design/cursor_linked_list_engine.sv
// Doubly linked list engine with a tracked cursor, nodes held in three
// single-port-read RAMs (data, next, prev) of NODES entries. A request word
// carries the request kind in s_tuser and the element value in s_tdata; each
// request returns exactly one result word with the read element, the length,
// the cursor position (-1 when undefined) and a status code. Requests are
// handled one at a time: the first RAM reads are issued as a request is
// accepted, then the sequencer steps through the second next-pointer read,
// the first write set, the second write set and the result load before it is
// back in idle. These steps follow from the two reads of the next-pointer RAM
// and the up to two writes an insert or delete makes to each pointer RAM. A
// new request word is taken as soon as the sequencer is back in idle, even
// while the previous result word waits in the output register.
// Failed requests leave all state untouched and report empty, cursor
// undefined or store full, checked in that order.
module cursor_linked_list_engine
    import clle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [3:0]  s_tuser,   // [3:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [31:0] read_data, [38:32] list_length,
                                   // [45:39] cursor_index, [47:46] status
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD2  = 5'b00010,
        S_EXEC = 5'b00100,
        S_WR2  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [PTR_W-1:0] front_reg, front_next, back_reg, back_next;
    logic [PTR_W-1:0] cur_reg, cur_next, free_reg, free_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] fresh_reg, fresh_next;
    logic signed [LEN_W-1:0] pos_reg, pos_next;

    req_t                 req_reg;
    logic [DATA_BITS-1:0] val_reg;
    logic [PTR_W-1:0]     tgt_reg, tgt_sel, nf_reg;
    logic [DATA_BITS-1:0] rd_reg, rd_next;
    logic [ST_W-1:0]      st_reg, st_next;

    // second write set, held from EXEC into WR2
    logic             nx2_we_reg, nx2_we_next, pv2_we_reg, pv2_we_next;
    logic [PTR_W-1:0] nx2_a_reg, nx2_a_next, nx2_d_reg, nx2_d_next;
    logic [PTR_W-1:0] pv2_a_reg, pv2_a_next, pv2_d_reg, pv2_d_next;

    logic             nx1_we, pv1_we, dt_we;
    logic [PTR_W-1:0] nx1_a, nx1_d, pv1_a, pv1_d, dt_a;

    logic             nx_we, pv_we, nx_re, rd_en;
    logic [IDX_W-1:0] nx_wa, pv_wa, nx_ra;
    logic [PTR_W-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
    logic [DATA_BITS-1:0] dt_rd;

    logic             out_valid_reg;
    logic [47:0]      out_data_reg;

    logic accept, empty, undef, have_free, can_alloc;
    logic [PTR_W-1:0] new_node, p_t, q_t;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // node addressed by the request: front, back or cursor
    always_comb
    begin
        unique case (req_t'(s_tuser))
            REQ_DEL_FRONT, REQ_RD_FRONT: tgt_sel = front_reg;
            REQ_DEL_BACK,  REQ_RD_BACK:  tgt_sel = back_reg;
            default:                     tgt_sel = cur_reg;
        endcase
    end

    assign rd_en = accept;
    assign nx_re = accept || (state_reg == S_RD2);
    assign nx_ra = (state_reg == S_RD2) ? tgt_reg[IDX_W-1:0] : free_reg[IDX_W-1:0];

    assign nx_we = (state_reg == S_EXEC) ? nx1_we : ((state_reg == S_WR2) && nx2_we_reg);
    assign nx_wa = (state_reg == S_EXEC) ? nx1_a[IDX_W-1:0] : nx2_a_reg[IDX_W-1:0];
    assign nx_wd = (state_reg == S_EXEC) ? nx1_d : nx2_d_reg;
    assign pv_we = (state_reg == S_EXEC) ? pv1_we : ((state_reg == S_WR2) && pv2_we_reg);
    assign pv_wa = (state_reg == S_EXEC) ? pv1_a[IDX_W-1:0] : pv2_a_reg[IDX_W-1:0];
    assign pv_wd = (state_reg == S_EXEC) ? pv1_d : pv2_d_reg;

    clle_ram #(.W(PTR_W), .D(NODES)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
        .re(nx_re), .raddr(nx_ra), .rdata(nx_rd)
    );

    clle_ram #(.W(PTR_W), .D(NODES)) u_prev (
        .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
        .re(rd_en), .raddr(tgt_sel[IDX_W-1:0]), .rdata(pv_rd)
    );

    clle_ram #(.W(DATA_BITS), .D(NODES)) u_data (
        .clk(clk), .we(dt_we && (state_reg == S_EXEC)), .waddr(dt_a[IDX_W-1:0]),
        .wdata(val_reg), .re(rd_en), .raddr(tgt_sel[IDX_W-1:0]), .rdata(dt_rd)
    );

    assign empty     = (count_reg == '0);
    assign undef     = (cur_reg == NIL);
    assign have_free = (free_reg != NIL);
    assign can_alloc = have_free || (fresh_reg < NIL);
    assign new_node  = have_free ? free_reg : fresh_reg;
    assign p_t       = pv_rd;   // prev of the addressed node
    assign q_t       = nx_rd;   // next of the addressed node

    // request execution: state update and both write sets
    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        cur_next   = cur_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        free_next  = free_reg;
        fresh_next = fresh_reg;
        rd_next    = '0;
        st_next    = ST_OK;
        nx1_we = 1'b0; nx1_a = new_node; nx1_d = NIL;
        pv1_we = 1'b0; pv1_a = new_node; pv1_d = NIL;
        dt_we  = 1'b0; dt_a  = new_node;
        nx2_we_next = 1'b0; nx2_a_next = new_node; nx2_d_next = new_node;
        pv2_we_next = 1'b0; pv2_a_next = new_node; pv2_d_next = new_node;

        unique case (req_reg)
            REQ_APPEND, REQ_PREPEND, REQ_INS_BEFORE, REQ_INS_AFTER:
            begin
                if ((req_reg == REQ_INS_BEFORE || req_reg == REQ_INS_AFTER) && empty)
                begin
                    st_next = ST_EMPTY;
                end
                else if ((req_reg == REQ_INS_BEFORE || req_reg == REQ_INS_AFTER) && undef)
                begin
                    st_next = ST_UNDEF;
                end
                else if (!can_alloc)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    if (have_free)
                    begin
                        free_next = nf_reg;
                    end
                    else
                    begin
                        fresh_next = fresh_reg + 1'b1;
                    end
                    dt_we      = 1'b1;
                    nx1_we     = 1'b1;
                    pv1_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    unique case (req_reg)
                        REQ_APPEND:
                        begin
                            pv1_d       = back_reg;
                            nx2_we_next = (back_reg != NIL);
                            nx2_a_next  = back_reg;
                            if (back_reg == NIL)
                            begin
                                front_next = new_node;
                            end
                            back_next = new_node;
                        end
                        REQ_PREPEND:
                        begin
                            nx1_d       = front_reg;
                            pv2_we_next = (front_reg != NIL);
                            pv2_a_next  = front_reg;
                            if (front_reg == NIL)
                            begin
                                back_next = new_node;
                            end
                            front_next = new_node;
                            if (!undef)
                            begin
                                pos_next = pos_reg + 7'sd1;
                            end
                        end
                        REQ_INS_BEFORE:
                        begin
                            nx1_d       = cur_reg;
                            pv1_d       = p_t;
                            nx2_we_next = (p_t != NIL);
                            nx2_a_next  = p_t;
                            if (p_t == NIL)
                            begin
                                front_next = new_node;
                            end
                            pv2_we_next = 1'b1;
                            pv2_a_next  = cur_reg;
                            pos_next    = pos_reg + 7'sd1;
                        end
                        default:
                        begin
                            pv1_d       = cur_reg;
                            nx1_d       = q_t;
                            pv2_we_next = (q_t != NIL);
                            pv2_a_next  = q_t;
                            if (q_t == NIL)
                            begin
                                back_next = new_node;
                            end
                            nx2_we_next = 1'b1;
                            nx2_a_next  = cur_reg;
                        end
                    endcase
                end
            end
            REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_CURSOR:
            begin
                if (empty)
                begin
                    st_next = ST_EMPTY;
                end
                else if (req_reg == REQ_DEL_CURSOR && undef)
                begin
                    st_next = ST_UNDEF;
                end
                else
                begin
                    nx1_we = (p_t != NIL); nx1_a = p_t; nx1_d = q_t;
                    pv1_we = (q_t != NIL); pv1_a = q_t; pv1_d = p_t;
                    if (p_t == NIL)
                    begin
                        front_next = q_t;
                    end
                    if (q_t == NIL)
                    begin
                        back_next = p_t;
                    end
                    nx2_we_next = 1'b1;
                    nx2_a_next  = tgt_reg;
                    nx2_d_next  = free_reg;
                    free_next   = tgt_reg;
                    count_next  = count_reg - 1'b1;
                    if (cur_reg == tgt_reg)
                    begin
                        cur_next = NIL;
                        pos_next = -7'sd1;
                    end
                    else if (req_reg == REQ_DEL_FRONT && !undef)
                    begin
                        pos_next = pos_reg - 7'sd1;
                    end
                end
            end
            REQ_MV_FRONT, REQ_MV_BACK:
            begin
                if (empty)
                begin
                    st_next = ST_EMPTY;
                end
                else if (req_reg == REQ_MV_FRONT)
                begin
                    cur_next = front_reg;
                    pos_next = '0;
                end
                else
                begin
                    cur_next = back_reg;
                    pos_next = $signed(count_reg - 1'b1);
                end
            end
            REQ_MV_PREV:
            begin
                if (!undef)
                begin
                    cur_next = p_t;
                    pos_next = (p_t == NIL) ? -7'sd1 : pos_reg - 7'sd1;
                end
            end
            REQ_MV_NEXT:
            begin
                if (!undef)
                begin
                    cur_next = q_t;
                    pos_next = (q_t == NIL) ? -7'sd1 : pos_reg + 7'sd1;
                end
            end
            REQ_RD_FRONT, REQ_RD_BACK:
            begin
                if (empty)
                begin
                    st_next = ST_EMPTY;
                end
                else
                begin
                    rd_next = dt_rd;
                end
            end
            REQ_RD_CURSOR, REQ_WR_CURSOR:
            begin
                if (empty)
                begin
                    st_next = ST_EMPTY;
                end
                else if (undef)
                begin
                    st_next = ST_UNDEF;
                end
                else if (req_reg == REQ_RD_CURSOR)
                begin
                    rd_next = dt_rd;
                end
                else
                begin
                    dt_we = 1'b1;
                    dt_a  = cur_reg;
                end
            end
            default:
            begin
                // splice the whole list onto the free list
                if (!empty)
                begin
                    nx1_we    = 1'b1;
                    nx1_a     = back_reg;
                    nx1_d     = free_reg;
                    free_next = front_reg;
                end
                front_next = NIL;
                back_next  = NIL;
                count_next = '0;
                cur_next   = NIL;
                pos_next   = -7'sd1;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_RD2 : S_IDLE;
            S_RD2:   state_next = S_EXEC;
            S_EXEC:  state_next = S_WR2;
            S_WR2:   state_next = S_DONE;
            S_DONE:  state_next = (!out_valid_reg || m_tready) ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= NIL;
            back_reg      <= NIL;
            cur_reg       <= NIL;
            free_reg      <= NIL;
            count_reg     <= '0;
            fresh_reg     <= '0;
            pos_reg       <= -7'sd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EXEC)
            begin
                front_reg <= front_next;
                back_reg  <= back_next;
                cur_reg   <= cur_next;
                free_reg  <= free_next;
                count_reg <= count_next;
                fresh_reg <= fresh_next;
                pos_reg   <= pos_next;
            end
            if (state_reg == S_DONE && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_t'(s_tuser);
            val_reg <= s_tdata;
            tgt_reg <= tgt_sel;
        end
        if (state_reg == S_RD2)
        begin
            nf_reg <= nx_rd;
        end
        if (state_reg == S_EXEC)
        begin
            rd_reg     <= rd_next;
            st_reg     <= st_next;
            nx2_we_reg <= nx2_we_next;
            nx2_a_reg  <= nx2_a_next;
            nx2_d_reg  <= nx2_d_next;
            pv2_we_reg <= pv2_we_next;
            pv2_a_reg  <= pv2_a_next;
            pv2_d_reg  <= pv2_d_next;
        end
        if (state_reg == S_DONE && (!out_valid_reg || m_tready))
        begin
            out_data_reg <= {st_reg, pos_reg, count_reg, rd_reg};
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LEN_W'(NODES))
        else $error("list length beyond store size");

    a_cursor_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg == NIL) == (pos_reg == -7'sd1))
        else $error("cursor pointer and position disagree");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (front_reg == NIL))
        else $error("empty flag and front pointer disagree");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside result load");

endmodule
